// ===== sv/smq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smq_pkg: shared types and constants for the stack with median query
// Request and status codes, controller states, and the command / status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package smq_pkg;

  localparam int KEY_BITS_DEF    = 16;
  localparam int STACK_DEPTH_DEF = 1024;

  localparam int REQ_W     = 2;
  localparam int IN_KEY_W  = 16;
  localparam int STS_W     = 2;
  localparam int RES_KEY_W = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2
  } req_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_POP_KEY,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SEL_RD,
    ST_SEL_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    clr_step;  // zero one tree node, advance clear pointer
    logic    accept;    // latch request
    logic    push;      // write stack top, count up, start leaf walk (+1)
    logic    pop_rd;    // count down, read stack top
    logic    pop_key;   // take popped key, start leaf walk (-1)
    logic    tree_rd;   // read tree node on update walk
    logic    tree_wr;   // write back adjusted count, move to parent
    logic    sel_init;  // start median descent at root
    logic    sel_rd;    // read left child
    logic    sel_step;  // choose child, adjust rank
    logic    set_res;   // load error result
    status_t res_code;
    logic    emit;      // load output register
  } smq_cmd_t;

  typedef struct packed {
    logic               clr_last;
    logic [REQ_W-1:0]   req;
    logic               empty;
    logic               full;
    logic               node_root;
    logic               last_level;
    logic               out_free;
  } smq_sts_t;

endpackage
`default_nettype wire

// ===== sv/smq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/smq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smq_ctrl: request sequencer
// Clears the count tree after reset, then runs one request at a time:
// stack access, tree update walk or median descent, result hand-off.
// ----------------------------------------------------------------------------
module smq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  smq_pkg::smq_sts_t  sts,
  output smq_pkg::smq_cmd_t  cmd
);

  smq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smq_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_code = smq_pkg::STS_OK;
    in_ready     = 1'b0;
    case (state_r)
      smq_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = smq_pkg::ST_IDLE;
        end
      end
      smq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = smq_pkg::ST_DISPATCH;
        end
      end
      smq_pkg::ST_DISPATCH: begin
        case (sts.req)
          smq_pkg::REQ_PUSH: begin
            if (sts.full) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = smq_pkg::STS_FULL;
              state_nxt    = smq_pkg::ST_EMIT;
            end else begin
              cmd.push  = 1'b1;
              state_nxt = smq_pkg::ST_UPD_RD;
            end
          end
          smq_pkg::REQ_POP: begin
            if (sts.empty) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = smq_pkg::STS_EMPTY;
              state_nxt    = smq_pkg::ST_EMIT;
            end else begin
              cmd.pop_rd = 1'b1;
              state_nxt  = smq_pkg::ST_POP_KEY;
            end
          end
          smq_pkg::REQ_PEEK: begin
            if (sts.empty) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = smq_pkg::STS_EMPTY;
              state_nxt    = smq_pkg::ST_EMIT;
            end else begin
              cmd.sel_init = 1'b1;
              state_nxt    = smq_pkg::ST_SEL_RD;
            end
          end
          default: begin
            state_nxt = smq_pkg::ST_IDLE;   // unused code: dropped
          end
        endcase
      end
      smq_pkg::ST_POP_KEY: begin
        cmd.pop_key = 1'b1;
        state_nxt   = smq_pkg::ST_UPD_RD;
      end
      smq_pkg::ST_UPD_RD: begin
        cmd.tree_rd = 1'b1;
        state_nxt   = smq_pkg::ST_UPD_WR;
      end
      smq_pkg::ST_UPD_WR: begin
        cmd.tree_wr = 1'b1;
        if (!sts.node_root) begin
          state_nxt = smq_pkg::ST_UPD_RD;
        end else if (sts.req == smq_pkg::REQ_POP) begin
          state_nxt = smq_pkg::ST_EMIT;
        end else begin
          state_nxt = smq_pkg::ST_IDLE;
        end
      end
      smq_pkg::ST_SEL_RD: begin
        cmd.sel_rd = 1'b1;
        state_nxt  = smq_pkg::ST_SEL_CMP;
      end
      smq_pkg::ST_SEL_CMP: begin
        cmd.sel_step = 1'b1;
        state_nxt    = sts.last_level ? smq_pkg::ST_EMIT : smq_pkg::ST_SEL_RD;
      end
      smq_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = smq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = smq_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/smq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smq_dp: datapath
// Stack memory and count, counting tree memory with its walk registers,
// result registers and the output register.
// ----------------------------------------------------------------------------
module smq_dp #(
  parameter int KEY_BITS    = smq_pkg::KEY_BITS_DEF,
  parameter int STACK_DEPTH = smq_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [smq_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [smq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  smq_pkg::smq_cmd_t                cmd,
  output smq_pkg::smq_sts_t                sts
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int NODE_W = KEY_BITS + 1;
  localparam int LVL_W  = $clog2(KEY_BITS);
  localparam int PAD_W  = smq_pkg::OUT_TDATA_W - smq_pkg::STS_W - smq_pkg::RES_KEY_W;

  // request
  logic [smq_pkg::REQ_W-1:0] req_r;
  logic [KEY_BITS-1:0]       key_r;

  // stack
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_dec;
  logic [KEY_BITS-1:0] stk_rdata;

  // tree walk
  logic [NODE_W-1:0]   clr_r;
  logic [NODE_W-1:0]   node_r;
  logic [CNT_W-1:0]    rank_r;
  logic [LVL_W-1:0]    level_r;
  logic                dec_r;
  logic [CNT_W-1:0]    tree_rdata;
  logic                tree_we;
  logic [NODE_W-1:0]   tree_waddr;
  logic [CNT_W-1:0]    tree_wdata;
  logic [NODE_W-1:0]   tree_raddr;
  logic [NODE_W-1:0]   left_node;
  logic [CNT_W:0]      half_sum;

  // result
  logic [smq_pkg::STS_W-1:0] res_sts_r;
  logic [KEY_BITS-1:0]       res_key_r;
  logic                      out_valid_r;
  logic [smq_pkg::OUT_TDATA_W-1:0] out_data_r;

  assign count_dec = count_r - CNT_W'(1);
  assign left_node = {node_r[KEY_BITS-1:0], 1'b0};
  assign half_sum  = {1'b0, count_r} + (CNT_W+1)'(1);

  smq_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(count_r[SP_W-1:0]),
    .wdata(key_r),
    .re   (cmd.pop_rd),
    .raddr(count_dec[SP_W-1:0]),
    .rdata(stk_rdata)
  );

  assign tree_we    = cmd.clr_step | cmd.tree_wr;
  assign tree_waddr = cmd.clr_step ? clr_r : node_r;
  assign tree_wdata = cmd.clr_step ? '0 :
                      (dec_r ? tree_rdata - CNT_W'(1) : tree_rdata + CNT_W'(1));
  assign tree_raddr = cmd.tree_rd ? node_r : left_node;

  smq_ram #(
    .WIDTH(CNT_W),
    .DEPTH(2 ** NODE_W)
  ) u_tree_ram (
    .clk  (clk),
    .we   (tree_we),
    .waddr(tree_waddr),
    .wdata(tree_wdata),
    .re   (cmd.tree_rd | cmd.sel_rd),
    .raddr(tree_raddr),
    .rdata(tree_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + NODE_W'(1);
      end
      if (cmd.push) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.pop_rd) begin
        count_r <= count_dec;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_tdata[smq_pkg::REQ_W-1:0];
      key_r <= KEY_BITS'(in_tdata[smq_pkg::REQ_W +: smq_pkg::IN_KEY_W]);
    end
    if (cmd.push) begin
      node_r <= {1'b1, key_r};
      dec_r  <= 1'b0;
    end
    if (cmd.pop_key) begin
      node_r    <= {1'b1, stk_rdata};
      dec_r     <= 1'b1;
      res_key_r <= stk_rdata;
      res_sts_r <= smq_pkg::STS_OK;
    end
    if (cmd.tree_wr) begin
      node_r <= node_r >> 1;
    end
    if (cmd.sel_init) begin
      node_r    <= NODE_W'(1);
      rank_r    <= half_sum[CNT_W:1];
      level_r   <= '0;
      res_sts_r <= smq_pkg::STS_OK;
    end
    if (cmd.sel_step) begin
      level_r <= level_r + LVL_W'(1);
      if (tree_rdata >= rank_r) begin
        node_r    <= left_node;
        res_key_r <= left_node[KEY_BITS-1:0];
      end else begin
        node_r    <= left_node | NODE_W'(1);
        res_key_r <= left_node[KEY_BITS-1:0] | KEY_BITS'(1);
        rank_r    <= rank_r - tree_rdata;
      end
    end
    if (cmd.set_res) begin
      res_sts_r <= cmd.res_code;
      res_key_r <= '0;
    end
    if (cmd.emit) begin
      out_data_r <= {PAD_W'(0), smq_pkg::RES_KEY_W'(res_key_r), res_sts_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_r == {NODE_W{1'b1}});
    sts.req        = req_r;
    sts.empty      = (count_r == '0);
    sts.full       = (count_r == CNT_W'(STACK_DEPTH));
    sts.node_root  = (node_r == NODE_W'(1));
    sts.last_level = (level_r == LVL_W'(KEY_BITS - 1));
    sts.out_free   = !out_valid_r || out_tready;
  end

endmodule
`default_nettype wire

// ===== sv/stack_with_median_query_core.sv =====
// The tree walk goes one level at a time: one read and one write (update) or one
//   read and one compare (descent) per tree level.
// Throughput: one request at a time.
// Reset: rst_n synchronous, active low; the stack empties at once, then a clearing
//   pass zeroes the count tree, in_tready low.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_with_median_query_core: LIFO key stack with median lookup
// Push, pop and peek-median requests over a stream interface. A counting
// tree over all key values, held in RAM, gives the median of stacked keys.
// ----------------------------------------------------------------------------
module stack_with_median_query_core #(
  parameter int KEY_BITS    = smq_pkg::KEY_BITS_DEF,
  parameter int STACK_DEPTH = smq_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [smq_pkg::IN_TDATA_W-1:0]  in_tdata,   // [1:0] req_type, [17:2] key
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [smq_pkg::OUT_TDATA_W-1:0] out_tdata   // [1:0] status, [17:2] result_key
);

  // Controller issues one command set per cycle; datapath reports back.
  smq_pkg::smq_cmd_t cmd;
  smq_pkg::smq_sts_t sts;

  smq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Datapath: stack RAM, tree RAM, walk registers, output register. The
  // output register lets a new request be taken while a result waits.
  smq_dp #(
    .KEY_BITS   (KEY_BITS),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // An accepted request blocks intake until it has been run.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while previous one in progress");

  // A result is only loaded when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result overwrote a pending one");

  // Every tree write-back follows the read of the same node.
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tree_wr |-> $past(cmd.tree_rd))
    else $error("tree write without preceding read");

  // Stack count never both empty and full.
  a_count_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.empty && sts.full))
    else $error("stack count corrupted");
`endif

endmodule
`default_nettype wire

// ===== test/tb_stack_with_median_query_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_with_median_query_core: self-checking bench for the median stack
// Drives push / pop / peek-median requests, including unknown codes, and
// predicts every result with a private stack and counting tree. Covers empty
// and full stacks, duplicate and extreme keys, random gaps on both channels
// and a long result-side hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_stack_with_median_query_core;
  import smq_pkg::*;

  localparam int KB         = KEY_BITS_DEF;
  localparam int SD         = STACK_DEPTH_DEF;
  localparam int LEAVES     = 1 << KB;
  localparam int QUIET_MAX  = 4 * (2 * LEAVES);  // well above the clear pass after reset
  localparam int DRAIN_CYC  = 4 * KB + 20;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    status_t          status;
    logic [15:0]      key;
  } median_result_t;

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic in_tvalid  = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [1:0] req_type, [17:2] key
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [1:0] status, [17:2] result_key

  // Predictor state: the stacked keys and a heap-ordered tally of key counts.
  logic [KB-1:0] key_stack [0:SD-1];
  int unsigned   key_tally [0:2*LEAVES-1];
  int            stack_depth = 0;

  median_result_t pending_results [$];

  int  errors      = 0;
  int  n_requests  = 0;
  int  n_results   = 0;
  int  n_full      = 0;
  int  n_empty     = 0;
  int  n_medians   = 0;
  int  quiet_cyc   = 0;
  int  rx_hold_req = 0;   // hold-off length handed to the result sink
  bit  tx_idle_on  = 1'b1;
  bit  rx_idle_on  = 1'b1;

  stack_with_median_query_core #(
    .KEY_BITS    (KB),
    .STACK_DEPTH (SD)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)      return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 20);
    else             return $urandom_range(50, 200);
  endfunction

  // Keys: full range, tight clusters (many duplicates), top of range, bit patterns.
  function automatic logic [15:0] rand_key();
    int unsigned sel;
    int unsigned b;
    sel = $urandom_range(0, 99);
    b   = $urandom_range(0, 15);
    if (sel < 40)      return 16'($urandom);
    else if (sel < 70) return 16'($urandom_range(0, 15));
    else if (sel < 85) return 16'hFFF0 | 16'($urandom_range(0, 15));
    else begin
      case ($urandom_range(0, 3))
        0:       return 16'h0000;
        1:       return 16'hFFFF;
        2:       return 16'(1 << b);
        default: return ~16'(1 << b);
      endcase
    end
  endfunction

  // Weighted request code; whatever is left over becomes the unknown code.
  function automatic logic [REQ_W-1:0] pick_req(int push_pct, int pop_pct, int peek_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct)                      return REQ_PUSH;
    if (r < push_pct + pop_pct)            return REQ_POP;
    if (r < push_pct + pop_pct + peek_pct) return REQ_PEEK;
    return REQ_UNKNOWN;
  endfunction

  // Walk from the leaf of k up to the root, adding delta at every node.
  task automatic tally_add(input logic [KB-1:0] k, input int delta);
    int node;
    node = LEAVES + int'(k);
    while (node >= 1) begin
      key_tally[node] = key_tally[node] + delta;
      node = node >> 1;
    end
  endtask

  // Apply one accepted request to the private copy; queue the result it causes.
  task automatic predict_request(input logic [REQ_W-1:0] req, input logic [15:0] key);
    median_result_t r;
    logic [KB-1:0]  k;
    int node;
    int unsigned rank;
    int left;
    k = key[KB-1:0];
    r.status = STS_OK;
    r.key    = '0;
    if (req == REQ_PUSH) begin
      if (stack_depth >= SD) begin
        // rejected push: stack and tally stay as they are
        r.status = STS_FULL;
        pending_results.push_back(r);
      end else begin
        key_stack[stack_depth] = k;
        stack_depth++;
        tally_add(k, 1);
      end
    end else if (req == REQ_UNKNOWN) begin
      // ignored entirely
    end else if (stack_depth == 0) begin
      r.status = STS_EMPTY;
      pending_results.push_back(r);
    end else if (req == REQ_POP) begin
      stack_depth--;
      r.key = 16'(key_stack[stack_depth]);
      tally_add(key_stack[stack_depth], -1);
      pending_results.push_back(r);
    end else begin
      // lower median: the ((n+1)/2)-th smallest key, found by tree descent
      rank = (stack_depth + 1) >> 1;
      node = 1;
      for (int lvl = 0; lvl < KB; lvl++) begin
        left = node << 1;
        if (key_tally[left] >= rank) begin
          node = left;
        end else begin
          rank = rank - key_tally[left];
          node = left | 1;
        end
      end
      r.key = 16'(node - LEAVES);
      pending_results.push_back(r);
    end
  endtask

  // Offer one request; entered and left at a falling edge.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [15:0] key);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-IN_KEY_W-REQ_W){1'b0}}, key, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(req, key);
    n_requests++;
    @(negedge clk);
  endtask

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin
    median_result_t exp_r;
    status_t        got_sts;
    logic [15:0]    got_key;
    if (rst_n && out_tvalid && out_tready) begin
      got_sts = status_t'(out_tdata[1:0]);
      got_key = out_tdata[17:2];
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got status %0d key 0x%04h",
                 $time, got_sts, got_key);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.status == STS_FULL)  n_full++;
        if (exp_r.status == STS_EMPTY) n_empty++;
        if (got_sts !== exp_r.status) begin
          $display("%0t ns: status mismatch, expected %0d, got %0d",
                   $time, exp_r.status, got_sts);
          errors++;
        end
        if (got_key !== exp_r.key) begin
          $display("%0t ns: result_key mismatch, expected 0x%04h, got 0x%04h",
                   $time, exp_r.key, got_key);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long with no request or result moving ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cyc = 0;
      end else begin
        quiet_cyc++;
        if (quiet_cyc >= QUIET_MAX) begin
          $display("%0t ns: watchdog, no traffic for %0d cycles", $time, quiet_cyc);
          $display("tb_stack_with_median_query_core: done, errors");
          $finish;
        end
      end
    end
  end

  // Result sink: random stalls, plus a long hold-off when one is requested.
  initial begin : result_sink
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Empty stack, unknown codes, extreme and repeated keys, median on odd and
  // even sizes, LIFO order on the way back down.
  task automatic test_directed();
    logic [REQ_W-1:0] reqs [22];
    logic [15:0]      keys [22];
    reqs = '{REQ_POP, REQ_PEEK, REQ_UNKNOWN, REQ_PUSH, REQ_PUSH, REQ_PEEK,
             REQ_PUSH, REQ_PEEK, REQ_PUSH, REQ_PEEK, REQ_POP, REQ_POP,
             REQ_POP, REQ_PEEK, REQ_POP, REQ_POP, REQ_PUSH, REQ_PUSH,
             REQ_PEEK, REQ_UNKNOWN, REQ_POP, REQ_POP};
    keys = '{16'hFFFF, 16'hFFFF, 16'h1234, 16'hFFFF, 16'h0000, 16'hFFFF,
             16'h8000, 16'h0000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000,
             16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA,
             16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF};
    for (int i = 0; i < 22; i++) send_request(reqs[i], keys[i]);
  endtask

  // Results held back for a long stretch while peeks and pops keep coming: the block
  // must stall its input and lose nothing.
  task automatic test_backpressure();
    tx_idle_on  = 1'b0;
    rx_hold_req = 3000;
    for (int i = 0; i < 4; i++) send_request(REQ_PUSH, rand_key());
    for (int i = 0; i < 10; i++) send_request((i % 5 == 4) ? REQ_POP : REQ_PEEK, 16'h0);
    tx_idle_on = 1'b1;
  endtask

  // Balanced mix on a shallow stack: frequent empty results, idling varied
  // in blocks so some stretches run with no gaps at all.
  task automatic test_random_mix();
    logic [REQ_W-1:0] req;
    int sent;
    sent = 0;
    while (sent < 150) begin
      if (sent % 50 == 0) begin
        tx_idle_on = $urandom_range(0, 1);
        rx_idle_on = $urandom_range(0, 1);
      end
      req = pick_req(44, 30, 23);
      send_request(req, rand_key());
      if (req != REQ_UNKNOWN) sent++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Push-heavy climb to a full stack with medians along the way, then
  // pushes against the full stack mixed with pops and peeks.
  task automatic test_fill_to_full();
    int blk;
    blk = 0;
    while (stack_depth < SD) begin
      if (blk % 200 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      blk++;
      send_request(pick_req(92, 3, 4), rand_key());
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 16; i++) send_request(pick_req(60, 15, 23), rand_key());
  endtask

  // Peek count for the summary line.
  always @(posedge clk) begin
    if (in_tvalid && in_tready && in_tdata[1:0] == REQ_PEEK) n_medians++;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    // in_tready stays low through the tree clearing pass; the first request waits
    test_directed();
    test_backpressure();
    test_random_mix();
    test_fill_to_full();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("requests %0d, results %0d, median requests %0d, peak stack depth %0d",
             n_requests, n_results, n_medians, SD);
    $display("empty-stack results %0d, full-stack rejections %0d, mismatches %0d",
             n_empty, n_full, errors);
    if (errors == 0) begin
      $display("tb_stack_with_median_query_core: done, clean");
    end else begin
      $display("tb_stack_with_median_query_core: done, errors");
    end
    $finish;
  end

endmodule

// ===== stack_with_median_query_core.f =====
sv/smq_pkg.sv
sv/smq_ram.sv
sv/smq_ctrl.sv
sv/smq_dp.sv
sv/stack_with_median_query_core.sv
test/tb_stack_with_median_query_core.sv
